// ===== design/nzp_pkg.sv =====
`timescale 1ns / 1ps

package nzp_pkg;

   // sizing
   localparam int ZONE_COUNT  = 4096;
   localparam int STACK_DEPTH = 64;
   localparam int ZONE_W      = 12;
   localparam int TICK_W      = 64;
   localparam int DEPTH_W     = 7;
   localparam int SLOT_W      = (ZONE_COUNT > 1) ? $clog2(ZONE_COUNT) : 1;
   localparam int STK_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

   // operation codes, code 3 behaves as a read
   typedef enum logic [1:0] {
      OP_ENTER = 2'd0,
      OP_EXIT  = 2'd1,
      OP_READ  = 2'd2
   } op_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2,
      ST_ZONE0 = 2'd3
   } status_type;

   // table slot of a zone number (zone count is a power of two)
   function automatic logic [SLOT_W-1:0] slot_of(input logic [ZONE_W-1:0] zone);
      logic [ZONE_W+SLOT_W-1:0] ext;
      ext = {{SLOT_W{1'b0}}, zone};
      return ext[SLOT_W-1:0];
   endfunction

   // frame count reported on the 7-bit depth field
   function automatic logic [DEPTH_W-1:0] depth_of(input logic [CNT_W-1:0] count);
      logic [CNT_W+DEPTH_W-1:0] ext;
      ext = {{DEPTH_W{1'b0}}, count};
      return ext[DEPTH_W-1:0];
   endfunction

endpackage

// ===== design/nested_zone_profiler_top.sv =====
`timescale 1ns / 1ps

// Nested zone profiler. Issue a transaction by raising start while busy is low;
// enter, read and every flagged case answer from the enter or report state, a
// good exit answers after the frame pop, parent update and zone update states
// through the counter tables, which have separate read and write ports. Each
// transaction gives exactly one result, shown for one cycle with rsp_valid; the
// receiver cannot stall it, so it must take the result in that cycle. After
// reset the block clears its counter tables, one entry per cycle, and holds busy
// high until the last entry is cleared and the first transaction can be taken.
module nested_zone_profiler_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   output logic                        busy,
   input  logic [1:0]                  req_operation,
   input  logic [nzp_pkg::ZONE_W-1:0]  req_zone,
   input  logic [nzp_pkg::TICK_W-1:0]  req_timestamp,
   output logic                        rsp_valid,
   output logic [1:0]                  rsp_status,
   output logic [nzp_pkg::ZONE_W-1:0]  rsp_zone_out,
   output logic [nzp_pkg::TICK_W-1:0]  rsp_hit_count,
   output logic [nzp_pkg::TICK_W-1:0]  rsp_exclusive_ticks,
   output logic [nzp_pkg::TICK_W-1:0]  rsp_inclusive_ticks,
   output logic [nzp_pkg::DEPTH_W-1:0] rsp_nesting_depth
);

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_ENTER,
      S_REPORT,
      S_POP,
      S_PARENT,
      S_ZONE
   } state_type;

   localparam int ZW = nzp_pkg::ZONE_W;
   localparam int TW = nzp_pkg::TICK_W;
   localparam int SW = nzp_pkg::SLOT_W;
   localparam int KW = nzp_pkg::STK_W;
   localparam int CW = nzp_pkg::CNT_W;
   localparam int DW = nzp_pkg::DEPTH_W;

   // counter tables and frame stack
   logic [TW-1:0] hit_mem  [nzp_pkg::ZONE_COUNT];
   logic [TW-1:0] excl_mem [nzp_pkg::ZONE_COUNT];
   logic [TW-1:0] incl_mem [nzp_pkg::ZONE_COUNT];
   logic [ZW-1:0] fparent_mem [nzp_pkg::STACK_DEPTH];
   logic [ZW-1:0] fzone_mem   [nzp_pkg::STACK_DEPTH];
   logic [TW-1:0] fstart_mem  [nzp_pkg::STACK_DEPTH];
   logic [TW-1:0] fprior_mem  [nzp_pkg::STACK_DEPTH];

   // registered read data
   logic [TW-1:0] rd_hit_ff, rd_excl_ff, rd_incl_ff;
   logic [ZW-1:0] stk_parent_ff, stk_zone_ff;
   logic [TW-1:0] stk_start_ff, stk_prior_ff;

   // control and work registers
   state_type     state_ff, state_in;
   logic [SW-1:0] clr_ff, clr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [ZW-1:0] parent_ff, parent_in;
   logic [ZW-1:0] zone_ff, zone_in;
   logic [TW-1:0] ts_ff, ts_in;
   logic [1:0]    status_ff, status_in;
   logic [ZW-1:0] fz_ff, fz_in;
   logic [ZW-1:0] fp_ff, fp_in;
   logic [TW-1:0] prior_ff, prior_in;
   logic [TW-1:0] cost_ff, cost_in;
   logic [TW-1:0] par_excl_ff, par_excl_in;

   // result registers
   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [ZW-1:0] rsp_zone_ff, rsp_zone_in;
   logic [TW-1:0] rsp_hit_ff, rsp_hit_in;
   logic [TW-1:0] rsp_excl_ff, rsp_excl_in;
   logic [TW-1:0] rsp_incl_ff, rsp_incl_in;
   logic [DW-1:0] rsp_depth_ff, rsp_depth_in;

   // memory port controls
   logic [SW-1:0] tbl_rd_addr, tbl_wr_addr;
   logic          hit_we, excl_we, incl_we;
   logic [TW-1:0] hit_wd, excl_wd, incl_wd;
   logic          stk_we;
   logic [CW-1:0] top_cnt;
   logic [KW-1:0] stk_rd_addr, stk_wr_addr;
   logic [TW-1:0] excl_base;

   assign top_cnt     = count_ff - 1'b1;
   assign stk_rd_addr = top_cnt[KW-1:0];
   assign stk_wr_addr = count_ff[KW-1:0];

   // counter tables: one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (hit_we) begin
         hit_mem[tbl_wr_addr] <= hit_wd;
      end
      if (excl_we) begin
         excl_mem[tbl_wr_addr] <= excl_wd;
      end
      if (incl_we) begin
         incl_mem[tbl_wr_addr] <= incl_wd;
      end
      rd_hit_ff  <= hit_mem[tbl_rd_addr];
      rd_excl_ff <= excl_mem[tbl_rd_addr];
      rd_incl_ff <= incl_mem[tbl_rd_addr];
   end

   // frame stack: push at the count, registered read of the top frame
   always_ff @(posedge clock) begin
      if (stk_we) begin
         fparent_mem[stk_wr_addr] <= parent_ff;
         fzone_mem[stk_wr_addr]   <= zone_ff;
         fstart_mem[stk_wr_addr]  <= ts_ff;
         fprior_mem[stk_wr_addr]  <= rd_incl_ff;
      end
      stk_parent_ff <= fparent_mem[stk_rd_addr];
      stk_zone_ff   <= fzone_mem[stk_rd_addr];
      stk_start_ff  <= fstart_mem[stk_rd_addr];
      stk_prior_ff  <= fprior_mem[stk_rd_addr];
   end

   // parent update of the same slot is forwarded to the zone update
   assign excl_base = (nzp_pkg::slot_of(fz_ff) == nzp_pkg::slot_of(fp_ff)) ?
                      par_excl_ff : rd_excl_ff;

   // sequencer next state and datapath
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      count_in     = count_ff;
      parent_in    = parent_ff;
      zone_in      = zone_ff;
      ts_in        = ts_ff;
      status_in    = status_ff;
      fz_in        = fz_ff;
      fp_in        = fp_ff;
      prior_in     = prior_ff;
      cost_in      = cost_ff;
      par_excl_in  = par_excl_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_zone_in  = rsp_zone_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_excl_in  = rsp_excl_ff;
      rsp_incl_in  = rsp_incl_ff;
      rsp_depth_in = rsp_depth_ff;
      tbl_rd_addr  = '0;
      tbl_wr_addr  = '0;
      hit_we       = 1'b0;
      excl_we      = 1'b0;
      incl_we      = 1'b0;
      hit_wd       = '0;
      excl_wd      = '0;
      incl_wd      = '0;
      stk_we       = 1'b0;

      case (state_ff)
         // zero every table entry after reset
         S_CLEAR: begin
            tbl_wr_addr = clr_ff;
            hit_we      = 1'b1;
            excl_we     = 1'b1;
            incl_we     = 1'b1;
            clr_in      = clr_ff + 1'b1;
            if (clr_ff == SW'(nzp_pkg::ZONE_COUNT - 1)) begin
               state_in = S_IDLE;
            end
         end

         // accept a transaction and issue the first table read
         S_IDLE: begin
            if (start) begin
               ts_in     = req_timestamp;
               zone_in   = req_zone;
               status_in = nzp_pkg::ST_OK;
               tbl_rd_addr = nzp_pkg::slot_of(req_zone);
               state_in  = S_REPORT;
               case (req_operation)
                  nzp_pkg::OP_ENTER: begin
                     if (req_zone == '0) begin
                        status_in = nzp_pkg::ST_ZONE0;
                     end else if (count_ff >= CW'(nzp_pkg::STACK_DEPTH)) begin
                        status_in = nzp_pkg::ST_FULL;
                     end else begin
                        state_in = S_ENTER;
                     end
                  end
                  nzp_pkg::OP_EXIT: begin
                     if (count_ff == '0) begin
                        status_in   = nzp_pkg::ST_EMPTY;
                        zone_in     = '0;
                        tbl_rd_addr = '0;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  default: begin
                     state_in = S_REPORT;
                  end
               endcase
            end
         end

         // count the hit and push the frame
         S_ENTER: begin
            tbl_wr_addr  = nzp_pkg::slot_of(zone_ff);
            hit_we       = 1'b1;
            hit_wd       = rd_hit_ff + 1'b1;
            stk_we       = 1'b1;
            count_in     = count_ff + 1'b1;
            parent_in    = zone_ff;
            rsp_valid_in = 1'b1;
            rsp_status_in = nzp_pkg::ST_OK;
            rsp_zone_in  = zone_ff;
            rsp_hit_in   = rd_hit_ff + 1'b1;
            rsp_excl_in  = rd_excl_ff;
            rsp_incl_in  = rd_incl_ff;
            rsp_depth_in = nzp_pkg::depth_of(count_ff + 1'b1);
            state_in     = S_IDLE;
         end

         // report counters unchanged
         S_REPORT: begin
            rsp_valid_in = 1'b1;
            rsp_status_in = status_ff;
            rsp_zone_in  = zone_ff;
            rsp_hit_in   = rd_hit_ff;
            rsp_excl_in  = rd_excl_ff;
            rsp_incl_in  = rd_incl_ff;
            rsp_depth_in = nzp_pkg::depth_of(count_ff);
            state_in     = S_IDLE;
         end

         // pop the top frame and take the cost
         S_POP: begin
            fz_in       = stk_zone_ff;
            fp_in       = stk_parent_ff;
            prior_in    = stk_prior_ff;
            cost_in     = ts_ff - stk_start_ff;
            count_in    = top_cnt;
            parent_in   = stk_parent_ff;
            tbl_rd_addr = nzp_pkg::slot_of(stk_parent_ff);
            state_in    = S_PARENT;
         end

         // charge the cost back out of the parent
         S_PARENT: begin
            tbl_wr_addr = nzp_pkg::slot_of(fp_ff);
            excl_we     = 1'b1;
            excl_wd     = rd_excl_ff - cost_ff;
            par_excl_in = rd_excl_ff - cost_ff;
            tbl_rd_addr = nzp_pkg::slot_of(fz_ff);
            state_in    = S_ZONE;
         end

         // add the cost to the zone and settle its inclusive total
         S_ZONE: begin
            tbl_wr_addr  = nzp_pkg::slot_of(fz_ff);
            excl_we      = 1'b1;
            incl_we      = 1'b1;
            excl_wd      = excl_base + cost_ff;
            incl_wd      = prior_ff + cost_ff;
            rsp_valid_in = 1'b1;
            rsp_status_in = nzp_pkg::ST_OK;
            rsp_zone_in  = fz_ff;
            rsp_hit_in   = rd_hit_ff;
            rsp_excl_in  = excl_base + cost_ff;
            rsp_incl_in  = prior_ff + cost_ff;
            rsp_depth_in = nzp_pkg::depth_of(count_ff);
            state_in     = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         count_ff     <= '0;
         parent_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         parent_ff    <= parent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      zone_ff       <= zone_in;
      ts_ff         <= ts_in;
      status_ff     <= status_in;
      fz_ff         <= fz_in;
      fp_ff         <= fp_in;
      prior_ff      <= prior_in;
      cost_ff       <= cost_in;
      par_excl_ff   <= par_excl_in;
      rsp_status_ff <= rsp_status_in;
      rsp_zone_ff   <= rsp_zone_in;
      rsp_hit_ff    <= rsp_hit_in;
      rsp_excl_ff   <= rsp_excl_in;
      rsp_incl_ff   <= rsp_incl_in;
      rsp_depth_ff  <= rsp_depth_in;
   end

   // ports
   assign busy                = (state_ff != S_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_status          = rsp_status_ff;
   assign rsp_zone_out        = rsp_zone_ff;
   assign rsp_hit_count       = rsp_hit_ff;
   assign rsp_exclusive_ticks = rsp_excl_ff;
   assign rsp_inclusive_ticks = rsp_incl_ff;
   assign rsp_nesting_depth   = rsp_depth_ff;

endmodule
